// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define NPC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define NPC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

// next-cycle implication that also runs during reset
`define NPC_ASSERT_NEXT_ALWAYS(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ----- sv/npc_pkg.sv -----
// types, constants and palette helpers for the nearest palette colour search
package npc_pkg;

  localparam int COLOR_W         = 8;
  localparam int IDX_W           = 8;
  localparam int DIST_W          = 18;
  localparam int LANES           = 4;
  localparam int DEFAULT_ENTRIES = 256;
  localparam int CUBE_FIRST      = 16;
  localparam int CUBE_LAST       = 231;
  localparam int CUBE_SIDE       = 6;
  localparam int LEVEL_MAX       = 255;
  localparam int LEVEL_DIV       = 5;

  localparam logic [COLOR_W-1:0] COARSE_MASK = 8'hFC;
  localparam logic [DIST_W-1:0]  DIST_NONE   = '1;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t               pixel;
    logic [IDX_W-1:0]   index;
    rgb_t               color;
    logic [DIST_W-1:0]  distance;
  } search_t;

  localparam rgb_t BASIC_COLORS [16] = '{
    '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
    '{8'd255, 8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255},
    '{8'd128, 8'd128, 8'd128}, '{8'd192, 8'd192, 8'd192},
    '{8'd64,  8'd64,  8'd64},  '{8'd255, 8'd128, 8'd0},
    '{8'd128, 8'd0,   8'd128}, '{8'd0,   8'd128, 8'd0},
    '{8'd0,   8'd0,   8'd128}, '{8'd128, 8'd128, 8'd0}
  };

  function automatic logic [COLOR_W-1:0] cube_level(input int k);
    return COLOR_W'((k * LEVEL_MAX) / LEVEL_DIV);
  endfunction

  // basic colours and cube entries; grays are built where the size is known
  function automatic rgb_t level_color(input int idx);
    int   j;
    rgb_t c;
    if (idx < CUBE_FIRST) begin
      c = BASIC_COLORS[idx[3:0]];
    end else begin
      j = idx - CUBE_FIRST;
      c.red   = cube_level(j / (CUBE_SIDE * CUBE_SIDE));
      c.green = cube_level((j / CUBE_SIDE) % CUBE_SIDE);
      c.blue  = cube_level(j % CUBE_SIDE);
    end
    return c;
  endfunction

endpackage

// ----- sv/npc_pixel_if.sv -----
// pixel input channel
interface npc_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [npc_pkg::COLOR_W-1:0]  red_in;
  logic [npc_pkg::COLOR_W-1:0]  green_in;
  logic [npc_pkg::COLOR_W-1:0]  blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ----- sv/npc_result_if.sv -----
// search result channel
interface npc_result_if;
  logic                         valid;
  logic                         ready;
  logic [npc_pkg::IDX_W-1:0]    palette_index;
  logic [npc_pkg::COLOR_W-1:0]  red_out;
  logic [npc_pkg::COLOR_W-1:0]  green_out;
  logic [npc_pkg::COLOR_W-1:0]  blue_out;
  logic [npc_pkg::DIST_W-1:0]   match_distance;

  modport source (output valid, output palette_index, output red_out, output green_out,
                  output blue_out, output match_distance, input ready);
  modport sink   (input valid, input palette_index, input red_out, input green_out,
                  input blue_out, input match_distance, output ready);
endinterface

// ----- sv/npc_stage.sv -----
// one search stage: compares the pixel with a group of palette entries
module npc_stage #(
  parameter int FIRST           = 0,
  parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  npc_pkg::search_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output npc_pkg::search_t out_data
);
  import npc_pkg::*;

  logic [DIST_W-1:0] lane_dist  [LANES];
  rgb_t              lane_color [LANES];
  logic [IDX_W-1:0]  lane_idx   [LANES];
  search_t           merged;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  for (genvar lane = 0; lane < LANES; lane++) begin : g_lane
    localparam int   IDX        = FIRST + lane;
    localparam int   GRAY       = (IDX * LEVEL_MAX) / (PALETTE_ENTRIES - 1);
    localparam rgb_t GRAY_COLOR = '{red: COLOR_W'(GRAY), green: COLOR_W'(GRAY),
                                    blue: COLOR_W'(GRAY)};
    localparam rgb_t COLOR      = (IDX > CUBE_LAST) ? GRAY_COLOR : level_color(IDX);

    assign lane_color[lane] = COLOR;
    assign lane_idx[lane]   = IDX_W'(IDX);

    if (IDX < PALETTE_ENTRIES) begin : g_used
      logic [COLOR_W-1:0]   dr, dg, db;
      logic [2*COLOR_W-1:0] sr, sg, sb;
      assign dr = abs_diff(in_data.pixel.red,   COLOR.red);
      assign dg = abs_diff(in_data.pixel.green, COLOR.green);
      assign db = abs_diff(in_data.pixel.blue,  COLOR.blue);
      assign sr = dr * dr;
      assign sg = dg * dg;
      assign sb = db * db;
      assign lane_dist[lane] = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    end else begin : g_unused
      assign lane_dist[lane] = DIST_NONE;
    end
  end

  // strict compares keep the lowest index on ties
  always_comb begin
    merged = in_data;
    for (int l = 0; l < LANES; l++) begin
      if (lane_dist[l] < merged.distance) begin
        merged.distance = lane_dist[l];
        merged.index    = lane_idx[l];
        merged.color    = lane_color[l];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= merged;
    end
  end

endmodule

// ----- sv/nearest_palette_color_top.sv -----
// top level of the nearest palette colour search pipeline
//
//   channel  | modport        | moves
//   ---------+----------------+-------------------------------------------
//   pixel    | npc_pixel_if   | rgb pixel in, one per transaction
//   result   | npc_result_if  | index, palette colour and squared distance
//   cfg      | wr_en/wr_data  | coarse_mode register write
//
// one pixel per cycle while result.ready does not stall the pipeline; each pixel passes every stage in turn
// each stage checks four palette entries and keeps the running nearest one
// reset empties the pipeline and sets coarse_mode to 1
// every stage has its own ready, so empty stages fill while a result waits
module nearest_palette_color_top #(
  parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  npc_pixel_if.sink    pixel,
  npc_result_if.source result
);
  import npc_pkg::*;

  localparam int NUM_STAGES = (PALETTE_ENTRIES + LANES - 1) / LANES;

  logic    coarse_mode;
  search_t stage_data  [NUM_STAGES+1];
  logic    stage_valid [NUM_STAGES+1];
  logic    stage_ready [NUM_STAGES+1];
  logic [COLOR_W-1:0] pix_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      coarse_mode <= cfg_wr_data;
    end
  end

  assign pix_mask = coarse_mode ? COARSE_MASK : '1;

  always_comb begin
    stage_data[0].pixel.red   = pixel.red_in   & pix_mask;
    stage_data[0].pixel.green = pixel.green_in & pix_mask;
    stage_data[0].pixel.blue  = pixel.blue_in  & pix_mask;
    stage_data[0].index       = '0;
    stage_data[0].color       = '0;
    stage_data[0].distance    = DIST_NONE;
  end

  assign stage_valid[0] = pixel.valid;
  assign pixel.ready    = stage_ready[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    npc_stage #(
      .FIRST           (s * LANES),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_data   (stage_data[s]),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_data  (stage_data[s+1])
    );
  end

  assign result.valid           = stage_valid[NUM_STAGES];
  assign stage_ready[NUM_STAGES] = result.ready;
  assign result.palette_index   = stage_data[NUM_STAGES].index;
  assign result.red_out         = stage_data[NUM_STAGES].color.red;
  assign result.green_out       = stage_data[NUM_STAGES].color.green;
  assign result.blue_out        = stage_data[NUM_STAGES].color.blue;
  assign result.match_distance  = stage_data[NUM_STAGES].distance;

endmodule

// ----- sv/npc_checker.sv -----
// port-level checks on the nearest palette colour search, bound to the top level
`include "assert_macros.svh"

module npc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         pix_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [npc_pkg::IDX_W-1:0]    res_index,
  input logic [npc_pkg::COLOR_W-1:0]  res_red,
  input logic [npc_pkg::COLOR_W-1:0]  res_green,
  input logic [npc_pkg::COLOR_W-1:0]  res_blue,
  input logic [npc_pkg::DIST_W-1:0]   res_dist
);
  import npc_pkg::*;

  localparam logic [DIST_W-1:0] MAX_DIST   = DIST_W'(3 * LEVEL_MAX * LEVEL_MAX);
  localparam logic [IDX_W-1:0]  GRAY_FIRST = IDX_W'(CUBE_LAST + 1);

  logic [IDX_W+3*COLOR_W+DIST_W-1:0] res_payload;
  logic                              res_gray;
  logic                              res_in_tail;

  assign res_payload = {res_index, res_red, res_green, res_blue, res_dist};
  assign res_gray    = (res_red == res_green) && (res_green == res_blue);
  assign res_in_tail = res_valid && (res_index >= GRAY_FIRST);

  // no result may come out of a pipeline that reset has just emptied
  `NPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !res_valid)

  // with no result waiting every stage has room
  `NPC_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !res_valid, pix_ready)

  // a stalled result holds
  `NPC_ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_payload))

  // distance stays in range
  `NPC_ASSERT_IMPLY(a_dist_range, clk, rst, res_valid, res_dist <= MAX_DIST)

  // the top of the palette is gray
  `NPC_ASSERT_IMPLY(a_gray_tail, clk, rst, res_in_tail, res_gray)

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pixel.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_index (result.palette_index),
  .res_red   (result.red_out),
  .res_green (result.green_out),
  .res_blue  (result.blue_out),
  .res_dist  (result.match_distance)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the nearest palette colour search pipeline
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  localparam int NUM_ENTRIES   = 256;
  localparam int PHASES        = 6;
  localparam int PHASE_PIXELS  = 280;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    rgb_t              color;
    logic [DIST_W-1:0] distance;
  } match_t;

  typedef struct packed {
    bit     coarse;
    rgb_t   px;
    bit     typed;
    match_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  npc_pixel_if  pixel_ch ();
  npc_result_if result_ch ();

  nearest_palette_color_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pixel       (pixel_ch),
    .result      (result_ch)
  );

  rgb_t      palette_rom [NUM_ENTRIES];
  match_t    pending_matches [$];
  stim_row_t directed_rows [$];

  bit     model_coarse;
  bit     drive_coarse;
  bit     typed_now;
  match_t typed_want;
  bit     tx_gaps_en;
  bit     rx_stall_en;

  int errors;
  int cycles;
  int n_pixels;
  int n_exact;
  int n_coarse;
  int n_results;
  int n_mode_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void build_palette();
    rgb_t basic [16];
    int   j;
    int   gray;
    basic = '{
      '{8'd0, 8'd0, 8'd0},     '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd0, 8'd0},   '{8'd0, 8'd255, 8'd0},
      '{8'd0, 8'd0, 8'd255},   '{8'd255, 8'd255, 8'd0},
      '{8'd255, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd255},
      '{8'd128, 8'd128, 8'd128}, '{8'd192, 8'd192, 8'd192},
      '{8'd64, 8'd64, 8'd64},  '{8'd255, 8'd128, 8'd0},
      '{8'd128, 8'd0, 8'd128}, '{8'd0, 8'd128, 8'd0},
      '{8'd0, 8'd0, 8'd128},   '{8'd128, 8'd128, 8'd0}
    };
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (i < 16) begin
        palette_rom[i] = basic[i];
      end else if (i <= 231) begin
        j = i - 16;
        palette_rom[i].red   = 8'((j / 36) * 255 / 5);
        palette_rom[i].green = 8'(((j / 6) % 6) * 255 / 5);
        palette_rom[i].blue  = 8'((j % 6) * 255 / 5);
      end else begin
        gray = i * 255 / (NUM_ENTRIES - 1);
        palette_rom[i] = '{8'(gray), 8'(gray), 8'(gray)};
      end
    end
  endfunction

  function automatic match_t nearest_color(rgb_t px, bit coarse);
    match_t best;
    int     best_d;
    int     d;
    int     dr;
    int     dg;
    int     db;
    if (coarse) begin
      px = rgb_t'(px & {3{8'hFC}});
    end
    best   = '0;
    best_d = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      dr = int'(px.red) - int'(palette_rom[i].red);
      dg = int'(px.green) - int'(palette_rom[i].green);
      db = int'(px.blue) - int'(palette_rom[i].blue);
      d  = dr * dr + dg * dg + db * db;
      if (i == 0 || d < best_d) begin
        best_d     = d;
        best.index = IDX_W'(i);
        best.color = palette_rom[i];
      end
    end
    best.distance = DIST_W'(best_d);
    return best;
  endfunction

  function automatic void queue_match(match_t m);
    pending_matches = {pending_matches, m};
  endfunction

  function automatic stim_row_t mk_row(bit coarse, int r, int g, int b, bit typed,
                                       int idx, int er, int eg, int eb, int d);
    stim_row_t row;
    row.coarse        = coarse;
    row.px            = '{8'(r), 8'(g), 8'(b)};
    row.typed         = typed;
    row.want.index    = IDX_W'(idx);
    row.want.color    = '{8'(er), 8'(eg), 8'(eb)};
    row.want.distance = DIST_W'(d);
    return row;
  endfunction

  function automatic logic [7:0] clamp_level(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // mix of uniform noise, near-palette colours, tie midpoints, grays and extremes
  function automatic rgb_t random_pixel();
    rgb_t px;
    rgb_t pa;
    rgb_t pb;
    int   sel;
    int   v;
    sel = $urandom_range(0, 9);
    pa  = palette_rom[$urandom_range(0, NUM_ENTRIES - 1)];
    pb  = palette_rom[$urandom_range(0, NUM_ENTRIES - 1)];
    if (sel <= 3) begin
      px = rgb_t'(24'($urandom));
    end else if (sel <= 6) begin
      px.red   = clamp_level(int'(pa.red) + int'($urandom_range(0, 12)) - 6);
      px.green = clamp_level(int'(pa.green) + int'($urandom_range(0, 12)) - 6);
      px.blue  = clamp_level(int'(pa.blue) + int'($urandom_range(0, 12)) - 6);
    end else if (sel == 7) begin
      px.red   = 8'((int'(pa.red) + int'(pb.red) + int'($urandom_range(0, 1))) / 2);
      px.green = 8'((int'(pa.green) + int'(pb.green) + int'($urandom_range(0, 1))) / 2);
      px.blue  = 8'((int'(pa.blue) + int'(pb.blue) + int'($urandom_range(0, 1))) / 2);
    end else if (sel == 8) begin
      v  = $urandom_range(0, 255);
      px = '{clamp_level(v + int'($urandom_range(0, 2)) - 1), 8'(v),
             clamp_level(v + int'($urandom_range(0, 2)) - 1)};
    end else begin
      px = rgb_t'(24'($urandom));
      if ($urandom_range(0, 2) == 0) px.red = 8'd0;
      else if ($urandom_range(0, 1) == 0) px.red = 8'd255;
      if ($urandom_range(0, 2) == 0) px.green = 8'd0;
      else if ($urandom_range(0, 1) == 0) px.green = 8'd255;
      if ($urandom_range(0, 2) == 0) px.blue = 8'd0;
      else if ($urandom_range(0, 1) == 0) px.blue = 8'd255;
    end
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                n_results, field, got, want));
    end
  endtask

  // transaction monitor and scoreboard
  always @(posedge clk) begin
    match_t want;
    if (!rst) begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (typed_now) begin
          queue_match(typed_want);
        end else begin
          queue_match(nearest_color({pixel_ch.red_in, pixel_ch.green_in,
                                     pixel_ch.blue_in}, model_coarse));
        end
        n_pixels++;
        if (model_coarse) n_coarse++;
        else n_exact++;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_matches.size() == 0) begin
          report_mismatch("result transaction with nothing pending");
        end else begin
          want = pending_matches.pop_front();
          check_field("palette_index", result_ch.palette_index, want.index);
          check_field("red_out", result_ch.red_out, want.color.red);
          check_field("green_out", result_ch.green_out, want.color.green);
          check_field("blue_out", result_ch.blue_out, want.color.blue);
          check_field("match_distance", result_ch.match_distance, want.distance);
        end
        n_results++;
      end
      if (cfg_wr_en) begin
        model_coarse = cfg_wr_data;
        n_mode_writes++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_matches.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      gap = rx_stall_en ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(rgb_t px, bit typed, match_t want);
    int gap;
    gap = tx_gaps_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      pixel_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid    = 1'b1;
    pixel_ch.red_in   = px.red;
    pixel_ch.green_in = px.green;
    pixel_ch.blue_in  = px.blue;
    typed_now         = typed;
    typed_want        = want;
    do @(posedge clk); while (!pixel_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pixel_ch.valid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(bit coarse);
    wait_drained();
    cfg_wr_en    = 1'b1;
    cfg_wr_data  = coarse;
    drive_coarse = coarse;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    pixel_ch.valid    = 1'b0;
    pixel_ch.red_in   = '0;
    pixel_ch.green_in = '0;
    pixel_ch.blue_in  = '0;
    model_coarse      = 1'b1;
    drive_coarse      = 1'b1;
    typed_now         = 1'b0;
    typed_want        = '0;
    tx_gaps_en        = 1'b1;
    rx_stall_en       = 1'b1;
    build_palette();

    directed_rows = '{
      mk_row(1, 0, 0, 0,         1, 0, 0, 0, 0, 0),
      mk_row(1, 255, 255, 255,   1, 252, 252, 252, 252, 0),
      mk_row(1, 3, 3, 3,         1, 0, 0, 0, 0, 0),
      mk_row(1, 255, 0, 0,       1, 2, 255, 0, 0, 9),
      mk_row(1, 0, 255, 0,       1, 3, 0, 255, 0, 9),
      mk_row(1, 0, 0, 255,       1, 4, 0, 0, 255, 9),
      mk_row(1, 130, 131, 129,   1, 8, 128, 128, 128, 0),
      mk_row(1, 17, 200, 99,     0, 0, 0, 0, 0, 0),
      mk_row(0, 255, 255, 255,   1, 1, 255, 255, 255, 0),
      mk_row(0, 0, 0, 0,         1, 0, 0, 0, 0, 0),
      mk_row(0, 255, 0, 255,     1, 6, 255, 0, 255, 0),
      mk_row(0, 0, 255, 255,     1, 7, 0, 255, 255, 0),
      mk_row(0, 192, 192, 192,   1, 9, 192, 192, 192, 0),
      mk_row(0, 64, 64, 64,      1, 10, 64, 64, 64, 0),
      mk_row(0, 255, 128, 0,     1, 11, 255, 128, 0, 0),
      mk_row(0, 128, 0, 128,     1, 12, 128, 0, 128, 0),
      mk_row(0, 0, 128, 0,       1, 13, 0, 128, 0, 0),
      mk_row(0, 0, 0, 128,       1, 14, 0, 0, 128, 0),
      mk_row(0, 128, 128, 0,     1, 15, 128, 128, 0, 0),
      mk_row(0, 51, 102, 153,    1, 67, 51, 102, 153, 0),
      mk_row(0, 240, 240, 240,   1, 240, 240, 240, 240, 0),
      mk_row(0, 255, 255, 254,   1, 1, 255, 255, 255, 1),
      mk_row(0, 1, 2, 3,         0, 0, 0, 0, 0, 0),
      mk_row(0, 254, 1, 128,     0, 0, 0, 0, 0, 0),
      mk_row(1, 127, 128, 129,   0, 0, 0, 0, 0, 0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].coarse != drive_coarse) begin
        write_mode(directed_rows[k].coarse);
      end
      send_pixel(directed_rows[k].px, directed_rows[k].typed, directed_rows[k].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // phase 2 runs flat out on both sides
      tx_gaps_en  = (ph != 2);
      rx_stall_en = (ph != 2);
      write_mode((ph == 0 || ph == 3 || ph == 5) ? 1'b1 : 1'b0);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (n == PHASE_PIXELS / 2) begin
          wait_drained();
        end
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end
    pixel_ch.valid = 1'b0;
    rx_stall_en    = 1'b1;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixels (%0d exact, %0d coarse) and %0d results",
             n_pixels, n_exact, n_coarse, n_results);
    $display("%0d mode register writes, %0d mismatches", n_mode_writes, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
